FILE: src/replica_block_partition_map_assert.svh
// ----------------------------------------------------------------------------
// Replica block partition map assertion macros
// Shared concurrent assertion forms for the checker of the partition map.
// ----------------------------------------------------------------------------
`ifndef REPLICA_BLOCK_PARTITION_MAP_ASSERT_SVH
`define REPLICA_BLOCK_PARTITION_MAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBPM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rbpm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBPM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rbpm assertion failed");

`endif

FILE: src/rbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica block partition map package
// Widths, defaults and register codes shared by the partition map files.
// ----------------------------------------------------------------------------
package rbpm_pkg;

    localparam int MAX_REPS_DEFAULT = 256;
    localparam int DIV_W            = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALANCE_MODE  = 3'd0,
        CFG_SOURCE_COUNT  = 3'd1,
        CFG_DEST_COUNT    = 3'd2,
        CFG_START_OFFSET  = 3'd3,
        CFG_RANK_STRIDE   = 3'd4,
        CFG_RANKS_PER_NODE = 3'd5,
        CFG_DOMAINS_PER_REP = 3'd6,
        CFG_INJECTION_DOMS = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_UNIFORM = 2'd0,
        MODE_NODE    = 2'd1,
        MODE_STRIDED = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quo;
        logic [DIV_W-1:0]   rem;
    } div_rsp_t;

endpackage

FILE: src/rbpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica block partition map channels
// Valid/ready channels for configuration writes, queries and results.
// ----------------------------------------------------------------------------
interface rbpm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rbpm_pkg::CFG_IDX_W-1:0]     index;
    logic [rbpm_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface rbpm_query_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rep_index;
    modport source (output valid, output op, output rep_index, input ready);
    modport sink (input valid, input op, input rep_index, output ready);
endinterface

interface rbpm_result_if;
    logic       valid;
    logic       ready;
    logic [8:0] range_start;
    logic [8:0] range_end;
    logic [7:0] source_rep;
    logic [8:0] dest_node_count;
    modport source (output valid, output range_start, output range_end,
                    output source_rep, output dest_node_count, input ready);
    modport sink (input valid, input range_start, input range_end,
                  input source_rep, input dest_node_count, output ready);
endinterface

FILE: src/rbpm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica block partition map divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbpm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rbpm_pkg::div_req_t  req,
    output rbpm_pkg::div_rsp_t  rsp
);

    localparam int W  = rbpm_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic          ge;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[W-1:0];

endmodule

FILE: src/replica_block_partition_map.sv
`timescale 1ns / 1ps
// Each query runs a series of divisions on the shared divider; a forward query in the
// node and strided modes may add a node scan over the destination replicas. A new query
// is accepted in the cycle after the previous result is loaded into the output register,
// so queries do not overlap. Reset is asynchronous and active low; it restores the
// register defaults and empties the result register.
// ----------------------------------------------------------------------------
// Replica block partition map
// Sequencer around one shared divider and multiplier that maps replica indices.
// ----------------------------------------------------------------------------
module replica_block_partition_map #(
    parameter int MAX_REPS = rbpm_pkg::MAX_REPS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rbpm_cfg_if.sink             cfg,
    rbpm_query_if.sink           query,
    rbpm_result_if.source        result
);

    localparam int W = rbpm_pkg::DIV_W;
    localparam logic [12:0] MAX_R = 13'(MAX_REPS);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_DN0   = 18'h00002,
        S_DSTEP = 18'h00004,
        S_MLAST = 18'h00008,
        S_DLAST = 18'h00010,
        S_MIDX  = 18'h00020,
        S_DIDX  = 18'h00040,
        S_DISP  = 18'h00080,
        S_DPER  = 18'h00100,
        S_MA    = 18'h00200,
        S_MB    = 18'h00400,
        S_DQ    = 18'h00800,
        S_DNINJ = 18'h01000,
        S_MTGT  = 18'h02000,
        S_DQ1   = 18'h04000,
        S_DQ2   = 18'h08000,
        S_SCAN  = 18'h10000,
        S_OUT   = 18'h20000
    } state_t;

    typedef enum logic [7:0] {
        P_FWD_UNI_GT = 8'h01,
        P_FWD_UNI_LT = 8'h02,
        P_FWD_NODE   = 8'h04,
        P_FWD_STR    = 8'h08,
        P_REV_UNI_GT = 8'h10,
        P_REV_UNI_LT = 8'h20,
        P_REV_NODE   = 8'h40,
        P_REV_STR    = 8'h80
    } path_t;

    logic [1:0]  mode_reg;
    logic [8:0]  sc_reg, dc_reg, rpn_reg, dpr_reg, inj_reg;
    logic [15:0] so_reg;
    logic [12:0] stride_reg;

    state_t      state_reg, state_next;
    path_t       path_reg, path_next;
    logic        issued_reg, issued_next;
    logic        op_reg, op_next;
    logic [7:0]  idx_reg, idx_next;
    logic [W-1:0] node0_reg, node0_next, qs_reg, qs_next, nn_reg, nn_next;
    logic [W-1:0] o_reg, o_next, per_reg, per_next, x_reg, x_next, qt_reg, qt_next;
    logic [W-1:0] off_reg, off_next;
    logic [8:0]  rem0_reg, rem0_next, rs_reg, rs_next, extra_reg, extra_next;
    logic [8:0]  ninj_reg, ninj_next, s_reg, s_next, e_reg, e_next, r_reg, r_next;
    logic [8:0]  srem_reg, srem_next;
    logic [7:0]  src_reg, src_next;
    logic [31:0] prod_reg, prod_next, thr_reg, thr_next, lo_reg, lo_next, hi_reg, hi_next;
    logic        found_reg, found_next;
    logic [8:0]  o_start_reg, o_end_reg, o_dnc_reg;
    logic [7:0]  o_src_reg;

    logic [8:0]  sc_e, dc_e, rpn_e, dpr_e, ninj_e;
    logic [8:0]  mul_a;
    logic [W-1:0] mul_b;
    logic [32:0] mul_full;
    logic [31:0] prod;
    logic        div_state;
    rbpm_pkg::div_req_t dreq;
    rbpm_pkg::div_rsp_t drsp;
    logic        lt_b, lt_q, hit, ov, load_out;
    logic [31:0] mb_first;
    logic [W-1:0] qd;
    logic [9:0]  s2;
    logic [8:0]  dnc;

    function automatic logic [8:0] eff_cnt(input logic [8:0] v, input logic [12:0] mx);
        logic [8:0] r;
        if (v == 9'd0)
            r = 9'd1;
        else if ({4'b0, v} > mx)
            r = mx[8:0];
        else
            r = v;
        return r;
    endfunction

    assign sc_e   = eff_cnt(sc_reg, MAX_R);
    assign dc_e   = eff_cnt(dc_reg, MAX_R);
    assign rpn_e  = (rpn_reg == 9'd0) ? 9'd1 : rpn_reg;
    assign dpr_e  = (dpr_reg == 9'd0) ? 9'd1 : dpr_reg;
    assign ninj_e = (ninj_reg == 9'd0) ? 9'd1 : ninj_reg;

    assign cfg.ready   = 1'b1;
    assign query.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            sc_reg     <= 9'd1;
            dc_reg     <= 9'd1;
            so_reg     <= 16'd0;
            stride_reg <= 13'd1;
            rpn_reg    <= 9'd8;
            dpr_reg    <= 9'd1;
            inj_reg    <= 9'd0;
        end
        else if (cfg.valid)
        begin
            unique case (rbpm_pkg::cfg_idx_t'(cfg.index))
                rbpm_pkg::CFG_BALANCE_MODE:    mode_reg   <= cfg.data[1:0];
                rbpm_pkg::CFG_SOURCE_COUNT:    sc_reg     <= cfg.data[8:0];
                rbpm_pkg::CFG_DEST_COUNT:      dc_reg     <= cfg.data[8:0];
                rbpm_pkg::CFG_START_OFFSET:    so_reg     <= cfg.data;
                rbpm_pkg::CFG_RANK_STRIDE:     stride_reg <= cfg.data[12:0];
                rbpm_pkg::CFG_RANKS_PER_NODE:  rpn_reg    <= cfg.data[8:0];
                rbpm_pkg::CFG_DOMAINS_PER_REP: dpr_reg    <= cfg.data[8:0];
                rbpm_pkg::CFG_INJECTION_DOMS:  inj_reg    <= cfg.data[8:0];
                default: ;
            endcase
        end
    end

    assign lt_b = x_reg < {15'b0, extra_reg};
    assign lt_q = {8'b0, x_reg} < thr_reg;

    always_comb
    begin
        mul_a = 9'd0;
        mul_b = '0;
        unique case (state_reg)
            S_MLAST:
            begin
                mul_a = dc_e - 9'd1;
                mul_b = W'(stride_reg);
            end
            S_MIDX:
            begin
                mul_a = {1'b0, idx_reg};
                mul_b = W'(stride_reg);
            end
            S_MA:
            begin
                mul_a = extra_reg;
                mul_b = per_reg + W'(1);
            end
            S_MB:
            begin
                mul_a = lt_b ? x_reg[8:0] : (x_reg[8:0] - extra_reg);
                mul_b = lt_b ? (per_reg + W'(1)) : per_reg;
            end
            S_MTGT:
            begin
                mul_a = {1'b0, idx_reg};
                mul_b = W'(dpr_e);
            end
            default: ;
        endcase
    end

    assign mul_full = {24'b0, mul_a} * {9'b0, mul_b};
    assign prod     = mul_full[31:0];
    assign mb_first = lt_b ? prod : (thr_reg + prod);

    assign div_state = (state_reg == S_DN0) || (state_reg == S_DSTEP) ||
                       (state_reg == S_DLAST) || (state_reg == S_DIDX) ||
                       (state_reg == S_DPER) || (state_reg == S_DQ) ||
                       (state_reg == S_DNINJ) || (state_reg == S_DQ1) ||
                       (state_reg == S_DQ2);

    always_comb
    begin
        dreq.start    = div_state && !issued_reg;
        dreq.dividend = '0;
        dreq.divisor  = W'(1);
        unique case (state_reg)
            S_DN0:
            begin
                dreq.dividend = W'(so_reg);
                dreq.divisor  = W'(rpn_e);
            end
            S_DSTEP:
            begin
                dreq.dividend = W'(stride_reg);
                dreq.divisor  = W'(rpn_e);
            end
            S_DLAST, S_DIDX:
            begin
                dreq.dividend = W'(so_reg) + prod_reg[W-1:0];
                dreq.divisor  = W'(rpn_e);
            end
            S_DPER:
            begin
                if (path_reg == P_FWD_UNI_GT || path_reg == P_REV_UNI_GT)
                begin
                    dreq.dividend = W'(sc_e);
                    dreq.divisor  = W'(dc_e);
                end
                else if (path_reg == P_FWD_UNI_LT || path_reg == P_REV_UNI_LT)
                begin
                    dreq.dividend = W'(dc_e);
                    dreq.divisor  = W'(sc_e);
                end
                else
                begin
                    dreq.dividend = nn_reg;
                    dreq.divisor  = W'(sc_e);
                end
            end
            S_DQ:
            begin
                dreq.dividend = lt_q ? x_reg : (x_reg - thr_reg[W-1:0]);
                dreq.divisor  = lt_q ? (per_reg + W'(1)) : per_reg;
            end
            S_DNINJ:
            begin
                dreq.dividend = W'(inj_reg);
                dreq.divisor  = W'(dpr_e);
            end
            S_DQ1:
            begin
                dreq.dividend = o_reg;
                dreq.divisor  = W'(dpr_e);
            end
            S_DQ2:
            begin
                dreq.dividend = qt_reg;
                dreq.divisor  = W'(ninj_e);
            end
            default: ;
        endcase
    end

    rbpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign qd  = lt_q ? drsp.quo : (W'(extra_reg) + drsp.quo);
    assign hit = ({8'b0, off_reg} >= lo_reg) && ({8'b0, off_reg} <= hi_reg);
    assign s2  = {1'b0, srem_reg} + {1'b0, rs_reg};
    assign ov  = s2 >= {1'b0, rpn_e};
    assign dnc = (nn_reg >= W'(511)) ? 9'd511 : nn_reg[8:0];
    assign load_out = (state_reg == S_OUT) && (!result.valid || result.ready);

    always_comb
    begin
        state_next  = state_reg;
        path_next   = path_reg;
        issued_next = issued_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        node0_next  = node0_reg;
        qs_next     = qs_reg;
        nn_next     = nn_reg;
        o_next      = o_reg;
        per_next    = per_reg;
        x_next      = x_reg;
        qt_next     = qt_reg;
        off_next    = off_reg;
        rem0_next   = rem0_reg;
        rs_next     = rs_reg;
        extra_next  = extra_reg;
        ninj_next   = ninj_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        r_next      = r_reg;
        srem_next   = srem_reg;
        src_next    = src_reg;
        prod_next   = prod_reg;
        thr_next    = thr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        found_next  = found_reg;

        if (dreq.start)
            issued_next = 1'b1;
        if (div_state && drsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (query.valid)
                begin
                    op_next    = query.op;
                    idx_next   = query.rep_index;
                    s_next     = 9'd0;
                    e_next     = 9'd0;
                    src_next   = 8'd0;
                    state_next = S_DN0;
                end
            end
            S_DN0:
            begin
                if (issued_reg && drsp.done)
                begin
                    node0_next = drsp.quo;
                    rem0_next  = drsp.rem[8:0];
                    state_next = S_DSTEP;
                end
            end
            S_DSTEP:
            begin
                if (issued_reg && drsp.done)
                begin
                    qs_next    = drsp.quo;
                    rs_next    = drsp.rem[8:0];
                    state_next = S_MLAST;
                end
            end
            S_MLAST:
            begin
                prod_next  = prod;
                state_next = S_DLAST;
            end
            S_DLAST:
            begin
                if (issued_reg && drsp.done)
                begin
                    nn_next    = drsp.quo - node0_reg + W'(1);
                    state_next = S_MIDX;
                end
            end
            S_MIDX:
            begin
                prod_next  = prod;
                state_next = S_DIDX;
            end
            S_DIDX:
            begin
                if (issued_reg && drsp.done)
                begin
                    o_next     = drsp.quo - node0_reg;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                x_next = W'(idx_reg);
                if (!op_reg)
                begin
                    if (mode_reg == rbpm_pkg::MODE_STRIDED)
                    begin
                        path_next  = P_FWD_STR;
                        state_next = S_DNINJ;
                    end
                    else if (mode_reg == rbpm_pkg::MODE_NODE)
                    begin
                        path_next = P_FWD_NODE;
                        if (W'(sc_e) >= nn_reg)
                        begin
                            lo_next    = 32'(idx_reg);
                            hi_next    = 32'(idx_reg);
                            state_next = (W'(idx_reg) >= nn_reg) ? S_OUT : S_SCAN;
                        end
                        else
                            state_next = S_DPER;
                    end
                    else if ({1'b0, idx_reg} >= sc_e)
                        state_next = S_OUT;
                    else if (sc_e == dc_e)
                    begin
                        s_next     = {1'b0, idx_reg};
                        e_next     = {1'b0, idx_reg} + 9'd1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        path_next  = (sc_e > dc_e) ? P_FWD_UNI_GT : P_FWD_UNI_LT;
                        state_next = S_DPER;
                    end
                end
                else
                begin
                    if ({1'b0, idx_reg} >= dc_e)
                        state_next = S_OUT;
                    else if (mode_reg == rbpm_pkg::MODE_STRIDED && inj_reg != 9'd0)
                    begin
                        path_next  = P_REV_STR;
                        state_next = S_DNINJ;
                    end
                    else if (mode_reg == rbpm_pkg::MODE_NODE ||
                             mode_reg == rbpm_pkg::MODE_STRIDED)
                    begin
                        path_next = P_REV_NODE;
                        x_next    = o_reg;
                        if (W'(sc_e) >= nn_reg)
                        begin
                            src_next   = o_reg[7:0];
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_DPER;
                    end
                    else if (sc_e == dc_e)
                    begin
                        src_next   = idx_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        path_next  = (sc_e > dc_e) ? P_REV_UNI_GT : P_REV_UNI_LT;
                        state_next = S_DPER;
                    end
                end
            end
            S_DPER:
            begin
                if (issued_reg && drsp.done)
                begin
                    per_next   = drsp.quo;
                    extra_next = drsp.rem[8:0];
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                thr_next = prod;
                if (path_reg == P_FWD_UNI_LT || path_reg == P_FWD_NODE ||
                    path_reg == P_REV_UNI_GT)
                    state_next = S_MB;
                else
                    state_next = S_DQ;
            end
            S_MB:
            begin
                if (path_reg == P_FWD_UNI_LT)
                begin
                    s_next     = mb_first[8:0];
                    e_next     = mb_first[8:0] + per_reg[8:0] + {8'b0, lt_b};
                    state_next = S_OUT;
                end
                else if (path_reg == P_FWD_NODE)
                begin
                    lo_next    = mb_first;
                    hi_next    = mb_first + 32'(per_reg) - {31'b0, !lt_b};
                    state_next = S_SCAN;
                end
                else
                begin
                    src_next   = mb_first[7:0];
                    state_next = S_OUT;
                end
            end
            S_DQ:
            begin
                if (issued_reg && drsp.done)
                begin
                    if (path_reg == P_FWD_UNI_GT)
                    begin
                        if (drsp.rem == '0 && qd < W'(dc_e))
                        begin
                            s_next = qd[8:0];
                            e_next = qd[8:0] + 9'd1;
                        end
                    end
                    else
                        src_next = qd[7:0];
                    state_next = S_OUT;
                end
            end
            S_DNINJ:
            begin
                if (issued_reg && drsp.done)
                begin
                    ninj_next  = drsp.quo[8:0];
                    state_next = (path_reg == P_FWD_STR) ? S_MTGT : S_DQ1;
                end
            end
            S_MTGT:
            begin
                lo_next    = prod;
                hi_next    = prod;
                state_next = (ninj_reg == 9'd0 || {1'b0, idx_reg} >= ninj_reg) ?
                             S_OUT : S_SCAN;
            end
            S_DQ1:
            begin
                if (issued_reg && drsp.done)
                begin
                    qt_next    = drsp.quo;
                    state_next = S_DQ2;
                end
            end
            S_DQ2:
            begin
                if (issued_reg && drsp.done)
                begin
                    src_next   = drsp.rem[7:0];
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (!found_reg)
                        s_next = r_reg;
                    found_next = 1'b1;
                    e_next     = r_reg + 9'd1;
                end
                if (path_reg == P_FWD_STR)
                    e_next = (found_reg || hit) ? dc_e : 9'd0;
                srem_next = ov ? (s2[8:0] - rpn_e) : s2[8:0];
                off_next  = off_reg + qs_reg + W'(ov);
                r_next    = r_reg + 9'd1;
                if (r_reg == dc_e - 9'd1)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (state_next == S_SCAN && state_reg != S_SCAN)
        begin
            r_next     = 9'd0;
            off_next   = '0;
            srem_next  = rem0_reg;
            found_next = 1'b0;
            s_next     = 9'd0;
            e_next     = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            path_reg     <= P_FWD_UNI_GT;
            issued_reg   <= 1'b0;
            result.valid <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            path_reg   <= path_next;
            issued_reg <= issued_next;
            if (load_out)
                result.valid <= 1'b1;
            else if (result.ready)
                result.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        node0_reg <= node0_next;
        qs_reg    <= qs_next;
        nn_reg    <= nn_next;
        o_reg     <= o_next;
        per_reg   <= per_next;
        x_reg     <= x_next;
        qt_reg    <= qt_next;
        off_reg   <= off_next;
        rem0_reg  <= rem0_next;
        rs_reg    <= rs_next;
        extra_reg <= extra_next;
        ninj_reg  <= ninj_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        r_reg     <= r_next;
        srem_reg  <= srem_next;
        src_reg   <= src_next;
        prod_reg  <= prod_next;
        thr_reg   <= thr_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        if (load_out)
        begin
            o_start_reg <= s_reg;
            o_end_reg   <= e_reg;
            o_src_reg   <= src_reg;
            o_dnc_reg   <= dnc;
        end
    end

    assign result.range_start     = o_start_reg;
    assign result.range_end       = o_end_reg;
    assign result.source_rep      = o_src_reg;
    assign result.dest_node_count = o_dnc_reg;

endmodule

FILE: src/rbpm_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replica block partition map checker
// Port-level assertions on the query and result channels of the partition map.
// ----------------------------------------------------------------------------
`include "replica_block_partition_map_assert.svh"

module rbpm_check (
    input logic       clk,
    input logic       rst_n,
    input logic       q_valid,
    input logic       q_ready,
    input logic       r_valid,
    input logic       r_ready,
    input logic [8:0] r_start,
    input logic [8:0] r_end,
    input logic [8:0] r_dnc
);

    `RBPM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, q_valid && q_ready, !q_ready)
    `RBPM_ASSERT_NXT(a_result_held, clk, rst_n, r_valid && !r_ready, r_valid)
    `RBPM_ASSERT_IMP(a_node_count_nonzero, clk, rst_n, r_valid, r_dnc != 9'd0)
    `RBPM_ASSERT_IMP(a_range_ordered, clk, rst_n, r_valid, r_end >= r_start)

endmodule

bind replica_block_partition_map rbpm_check u_rbpm_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (query.valid),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_start (result.range_start),
    .r_end   (result.range_end),
    .r_dnc   (result.dest_node_count)
);
